[rtl/rwmc_pkg.sv]
`timescale 1ns / 1ps

package rwmc_pkg;

  localparam int GRID_SIDE = 16;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W    = 2 * COORD_W;
  localparam int CNT_W     = CELL_W + 1;
  localparam int CHAR_W    = 6;
  localparam int RND_W     = 15;

  // neighbor order: left, right, up, down
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIDE - 1);

  typedef struct packed {
    logic                 en;
    logic [COORD_W-1:0]   addr;
    logic [GRID_SIDE-1:0] data;
  } row_wr_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ord_wr_t;

  // value mod 3: base-4 digits sum to the same residue
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
    logic [15:0] w;
    logic [4:0]  s;
    logic [3:0]  s2;
    logic [2:0]  s3;
    logic [1:0]  res;
    w = {1'b0, v};
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(w[2*i +: 2]);
    end
    s2 = 4'(s[4:2]) + 4'(s[1:0]);
    s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
    if (s3 >= 3'd6) begin
      res = 2'(s3 - 3'd6);
    end else if (s3 >= 3'd3) begin
      res = 2'(s3 - 3'd3);
    end else begin
      res = s3[1:0];
    end
    return res;
  endfunction

endpackage

[rtl/random_walk_maze_carver_top.sv]
`timescale 1ns / 1ps

// Hunt-and-kill maze carver over a 16 x 16 grid.
// Input channel (in_valid/in_ready/in_random_value): one random word per item;
// each item makes one step of the walk. Result channel (out_valid/out_ready and
// the out_ fields): exactly one result item per input item, in order.
// A result reports the opened wall and cell in the doubled character grid when
// the walk moved, all zero on a back-jump, and done_res once the walk is over.
// Order: a move goes S_IDLE, S_RD2, S_EVAL and registers its result; a back-jump
// goes on to S_HUNT (an extra read of the visit-order memory); a step after the
// end goes through S_FIN. The current row and the row above are read through the
// two read ports of the row memory, then the current row is written back.
// The block works on one item at a time; in_ready is high whenever no step is
// in flight, even while a result waits in the output register.
// Reset: synchronous, active low; the walk restarts at cell 0 with only that
// cell visited. Row valid bits clear at once, so there is no clearing pass.
// Receiver stall: the finished result holds in the output register; a new item
// may be accepted but its result is held back until the register drains.
module random_walk_maze_carver_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rwmc_pkg::RND_W-1:0]    in_random_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_moved,
  output logic [rwmc_pkg::CHAR_W-1:0]   out_wall_col,
  output logic [rwmc_pkg::CHAR_W-1:0]   out_wall_row,
  output logic [rwmc_pkg::CHAR_W-1:0]   out_cell_col,
  output logic [rwmc_pkg::CHAR_W-1:0]   out_cell_row,
  output logic                          out_done_res
);

  localparam int CW = rwmc_pkg::COORD_W;
  localparam int GS = rwmc_pkg::GRID_SIDE;
  localparam int XW = rwmc_pkg::CHAR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD2  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_HUNT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // walk state
  logic [CW-1:0]              cx_r, cx_nxt, cy_r, cy_nxt;
  logic [rwmc_pkg::CNT_W-1:0] vcnt_r, vcnt_nxt, hunt_r, hunt_nxt;
  logic                       fin_r, fin_nxt;

  // per-step payload
  logic [rwmc_pkg::RND_W-1:0] rnd_r;
  logic [1:0]                 rnd_m3_r;
  logic [GS-1:0]              row_cur_r, row_up_r;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          moved_r, done_r;
  logic [XW-1:0] wc_r, wr_r, cc_r, cr_r;
  logic          emit;
  logic          emit_moved, emit_done;
  logic [XW-1:0] e_wc, e_wr, e_cc, e_cr;

  // memory ports
  rwmc_pkg::row_wr_t           row_wr;
  rwmc_pkg::ord_wr_t           ord_wr;
  logic                        rd_a_en, rd_b_en, ord_rd_en;
  logic [CW-1:0]               rd_a_addr, rd_b_addr;
  logic [GS-1:0]               rd_a_data, rd_b_data;
  logic [rwmc_pkg::CELL_W-1:0] ord_rd_data;
  logic [rwmc_pkg::CELL_W-1:0] hunt_cell;

  // neighbor evaluation
  logic [3:0]    free;
  logic [2:0]    cnt;
  logic [1:0]    pick;
  logic [1:0]    sel;
  logic [2:0]    idx;
  logic          found;
  logic          in_acc, slot_free;
  logic [GS-1:0] cur_bit;

  rwmc_vis_mem u_vis (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (row_wr),
    .rd_a_en   (rd_a_en),
    .rd_a_addr (rd_a_addr),
    .rd_b_en   (rd_b_en),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  rwmc_ord_mem u_ord (
    .clk     (clk),
    .wr      (ord_wr),
    .rd_en   (ord_rd_en),
    .rd_addr (hunt_r[rwmc_pkg::CELL_W-1:0]),
    .rd_data (ord_rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cur_bit   = GS'(1) << cx_r;

  // entry 0 of the visit order is cell 0 from reset and is never written
  assign hunt_cell = (hunt_r == '0) ? '0 : ord_rd_data;

  // free neighbors; row_dn comes straight off read port A in S_EVAL
  always_comb begin
    free[rwmc_pkg::DIR_LEFT]  = (cx_r != '0) && !row_cur_r[cx_r - CW'(1)];
    free[rwmc_pkg::DIR_RIGHT] = (cx_r != rwmc_pkg::COORD_MAX) && !row_cur_r[cx_r + CW'(1)];
    free[rwmc_pkg::DIR_UP]    = (cy_r != '0) && !row_up_r[cx_r];
    free[rwmc_pkg::DIR_DOWN]  = (cy_r != rwmc_pkg::COORD_MAX) && !rd_a_data[cx_r];
    cnt = 3'(free[0]) + 3'(free[1]) + 3'(free[2]) + 3'(free[3]);
    case (cnt)
      3'd2:    pick = {1'b0, rnd_r[0]};
      3'd3:    pick = rnd_m3_r;
      3'd4:    pick = rnd_r[1:0];
      default: pick = 2'd0;
    endcase
    sel   = rwmc_pkg::DIR_LEFT;
    idx   = '0;
    found = 1'b0;
    for (int d = 0; d < 4; d++) begin
      if (free[d]) begin
        if (!found && idx == {1'b0, pick}) begin
          sel   = 2'(d);
          found = 1'b1;
        end
        idx = idx + 3'd1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    vcnt_nxt      = vcnt_r;
    hunt_nxt      = hunt_r;
    fin_nxt       = fin_r;
    rd_a_en       = 1'b0;
    rd_a_addr     = cy_r;
    rd_b_en       = 1'b0;
    rd_b_addr     = cy_r;
    ord_rd_en     = 1'b0;
    row_wr        = '0;
    ord_wr        = '0;
    emit          = 1'b0;
    emit_moved    = 1'b0;
    emit_done     = 1'b0;
    e_wc          = '0;
    e_wr          = '0;
    e_cc          = '0;
    e_cr          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (fin_r) begin
            state_nxt = S_FIN;
          end else begin
            // fetch the current row and the row above
            rd_a_en   = 1'b1;
            rd_b_en   = 1'b1;
            rd_b_addr = (cy_r == '0) ? cy_r : cy_r - CW'(1);
            state_nxt = S_RD2;
          end
        end
      end
      S_RD2: begin
        // mark the current cell, append it if new, fetch the row below
        row_wr.en   = 1'b1;
        row_wr.addr = cy_r;
        row_wr.data = rd_a_data | cur_bit;
        if (!rd_a_data[cx_r] && vcnt_r < rwmc_pkg::CNT_W'(rwmc_pkg::CELLS)) begin
          ord_wr.en   = 1'b1;
          ord_wr.addr = vcnt_r[rwmc_pkg::CELL_W-1:0];
          ord_wr.data = {cy_r, cx_r};
          vcnt_nxt    = vcnt_r + rwmc_pkg::CNT_W'(1);
        end
        rd_a_en   = 1'b1;
        rd_a_addr = (cy_r == rwmc_pkg::COORD_MAX) ? cy_r : cy_r + CW'(1);
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (slot_free) begin
          if (cnt != '0) begin
            emit       = 1'b1;
            emit_moved = 1'b1;
            state_nxt  = S_IDLE;
            case (sel)
              rwmc_pkg::DIR_LEFT: begin
                cx_nxt = cx_r - CW'(1);
                e_wc   = {1'b0, cx_r, 1'b0};
                e_wr   = {1'b0, cy_r, 1'b1};
              end
              rwmc_pkg::DIR_RIGHT: begin
                cx_nxt = cx_r + CW'(1);
                e_wc   = {1'b0, cx_r, 1'b0} + XW'(2);
                e_wr   = {1'b0, cy_r, 1'b1};
              end
              rwmc_pkg::DIR_UP: begin
                cy_nxt = cy_r - CW'(1);
                e_wc   = {1'b0, cx_r, 1'b1};
                e_wr   = {1'b0, cy_r, 1'b0};
              end
              rwmc_pkg::DIR_DOWN: begin
                cy_nxt = cy_r + CW'(1);
                e_wc   = {1'b0, cx_r, 1'b1};
                e_wr   = {1'b0, cy_r, 1'b0} + XW'(2);
              end
              default: begin
                cx_nxt = cx_r;
              end
            endcase
            e_cc = {1'b0, cx_nxt, 1'b1};
            e_cr = {1'b0, cy_nxt, 1'b1};
          end else if (vcnt_r >= rwmc_pkg::CNT_W'(rwmc_pkg::CELLS) || hunt_r >= vcnt_r) begin
            fin_nxt   = 1'b1;
            emit      = 1'b1;
            emit_done = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ord_rd_en = 1'b1;
            state_nxt = S_HUNT;
          end
        end
      end
      S_HUNT: begin
        if (slot_free) begin
          cx_nxt    = hunt_cell[CW-1:0];
          cy_nxt    = hunt_cell[rwmc_pkg::CELL_W-1:CW];
          hunt_nxt  = hunt_r + rwmc_pkg::CNT_W'(1);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cx_r        <= '0;
      cy_r        <= '0;
      vcnt_r      <= rwmc_pkg::CNT_W'(1);
      hunt_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      vcnt_r      <= vcnt_nxt;
      hunt_r      <= hunt_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rnd_r    <= in_random_value;
      rnd_m3_r <= rwmc_pkg::mod3(in_random_value);
    end
    if (state_r == S_RD2) begin
      row_cur_r <= rd_a_data | cur_bit;
      row_up_r  <= rd_b_data;
    end
    if (emit) begin
      moved_r <= emit_moved;
      done_r  <= emit_done;
      wc_r    <= e_wc;
      wr_r    <= e_wr;
      cc_r    <= e_cc;
      cr_r    <= e_cr;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_moved    = moved_r;
  assign out_wall_col = wc_r;
  assign out_wall_row = wr_r;
  assign out_cell_col = cc_r;
  assign out_cell_row = cr_r;
  assign out_done_res = done_r;

endmodule

[rtl/rwmc_vis_mem.sv]
`timescale 1ns / 1ps

// Visited bitmap, one grid row per word, two read ports and one write port.
// A row never written reads as its reset value (only cell 0 set).
module rwmc_vis_mem (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rwmc_pkg::row_wr_t                      wr,
  input  logic                                   rd_a_en,
  input  logic [rwmc_pkg::COORD_W-1:0]           rd_a_addr,
  input  logic                                   rd_b_en,
  input  logic [rwmc_pkg::COORD_W-1:0]           rd_b_addr,
  output logic [rwmc_pkg::GRID_SIDE-1:0]         rd_a_data,
  output logic [rwmc_pkg::GRID_SIDE-1:0]         rd_b_data
);

  localparam logic [rwmc_pkg::GRID_SIDE-1:0] ROW0_INIT = rwmc_pkg::GRID_SIDE'(1);

  logic [rwmc_pkg::GRID_SIDE-1:0] mem [rwmc_pkg::GRID_SIDE];
  logic [rwmc_pkg::GRID_SIDE-1:0] row_vld_r;
  logic [rwmc_pkg::GRID_SIDE-1:0] q_a_r, q_b_r;
  logic                           vld_a_r, vld_b_r;
  logic                           zero_a_r, zero_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_a_en) begin
      q_a_r    <= mem[rd_a_addr];
      zero_a_r <= (rd_a_addr == '0);
    end
    if (rd_b_en) begin
      q_b_r    <= mem[rd_b_addr];
      zero_b_r <= (rd_b_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
    end else begin
      if (wr.en) begin
        row_vld_r[wr.addr] <= 1'b1;
      end
      if (rd_a_en) begin
        vld_a_r <= row_vld_r[rd_a_addr];
      end
      if (rd_b_en) begin
        vld_b_r <= row_vld_r[rd_b_addr];
      end
    end
  end

  assign rd_a_data = vld_a_r ? q_a_r : (zero_a_r ? ROW0_INIT : '0);
  assign rd_b_data = vld_b_r ? q_b_r : (zero_b_r ? ROW0_INIT : '0);

endmodule

[rtl/rwmc_ord_mem.sv]
`timescale 1ns / 1ps

// Visit-order list: cell numbers in the order they were first entered.
module rwmc_ord_mem (
  input  logic                          clk,
  input  rwmc_pkg::ord_wr_t             wr,
  input  logic                          rd_en,
  input  logic [rwmc_pkg::CELL_W-1:0]   rd_addr,
  output logic [rwmc_pkg::CELL_W-1:0]   rd_data
);

  logic [rwmc_pkg::CELL_W-1:0] mem [rwmc_pkg::CELLS];
  logic [rwmc_pkg::CELL_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule
